[rtl/core/bbt_pkg.sv]
// Shared types and constants of the Bollinger band tracker.
package bbt_pkg;

    localparam int PRICE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int WL_W       = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int BAND_W     = 48;
    localparam int BWID_W     = 32;
    localparam int GAIN_FRAC  = 8;
    // bandwidth = 4 * dev / mean in Q16.16, so dev is scaled by 2^18
    localparam int BW_FRAC    = 18;
    // quotient fits the bandwidth word only while dev < mean << 14
    localparam int BW_LIM_SH  = BWID_W - BW_FRAC;
    localparam int OFF_W      = PRICE_W + GAIN_W - GAIN_FRAC;

    localparam logic [WL_W-1:0]   WL_RST   = 7'd20;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'd1;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_BW
    } bbt_div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_UPDATE,
        ST_MEAN_S,
        ST_MEAN_W,
        ST_WALK_S,
        ST_WALK_W,
        ST_VAR_S,
        ST_VAR_W,
        ST_SQRT_S,
        ST_SQRT_W,
        ST_MUL,
        ST_BW_S,
        ST_BW_W,
        ST_OUT
    } bbt_state_t;

    typedef struct packed {
        logic         cap;
        logic         rd_old;
        logic         update;
        logic         div_start;
        bbt_div_sel_t div_sel;
        logic         walk_start;
        logic         sqrt_start;
        logic         mul;
        logic         bw_sat;
        logic         emit;
    } bbt_cmd_t;

    typedef struct packed {
        logic will_emit;
        logic div_done;
        logic walk_done;
        logic sqrt_done;
        logic bw_sat;
        logic out_free;
    } bbt_status_t;

endpackage

[rtl/core/bollinger_band_tracker_core.sv]
// Top level of the Bollinger band tracker: controller plus datapath.
//
// Input channel: one price word (unsigned Q16.16) per accepted handshake
// (in_valid high, in_stall low). Output channel: one word of upper_band,
// lower_band (signed Q31.16) and bandwidth (Q16.16) per full window.
// Config port: cfg_write with cfg_index 0 sets window_length and restarts
// filling; index 1 sets deviation_gain (Q8.8). Write only while idle.
// An item that does not fill the window yields nothing. An item with a
// full window runs the mean divide, the ring walk, the variance divide,
// the square root and the bandwidth divide in turn; the shared serial
// divider works out 39, 71 and 50 quotient bits, one per cycle, and the
// square root 32 root bits. The bandwidth divide is skipped when the
// bandwidth saturates. One item is in work at a time.
// Reset clears the sum, write pointer and fill count and loads window 20,
// gain 2.0; the ring itself is not cleared. A finished word waits in the
// output register while out_stall is high; the next price is accepted
// meanwhile and its own result waits until that register frees.
module bollinger_band_tracker_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bbt_pkg::PRICE_W-1:0]        price,
    input  logic                               cfg_write,
    input  logic [bbt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbt_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bbt_pkg::BAND_W-1:0]  upper_band,
    output logic signed [bbt_pkg::BAND_W-1:0]  lower_band,
    output logic [bbt_pkg::BWID_W-1:0]         bandwidth
);
    import bbt_pkg::*;

    bbt_cmd_t    cmd;
    bbt_status_t st;

    bbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bbt_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .price      (price),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .upper_band (upper_band),
        .lower_band (lower_band),
        .bandwidth  (bandwidth)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    a_var_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        st.walk_done |=> cmd.div_start && (cmd.div_sel == DIV_VAR))
        else $error("variance divide did not follow window walk");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result emitted over a held word");
`endif

endmodule

[rtl/core/bbt_div.sv]
// Restoring divider, one quotient bit per cycle.
module bbt_div #(
    parameter int DW = 71,
    parameter int VW = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DW-1:0]          dividend,
    input  logic [$clog2(DW+1)-1:0] iters,
    input  logic [VW-1:0]          divisor,
    output logic                   done,
    output logic [DW-1:0]          quotient
);
    localparam int CNW = $clog2(DW+1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [DW-1:0]  dvd_reg;
    logic [DW-1:0]  quo_reg;
    logic [VW-1:0]  rem_reg;
    logic [VW-1:0]  dsr_reg;
    logic [VW:0]    shifted;
    logic [VW:0]    diff;
    logic           ge;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DW-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = shifted >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : shifted[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
            dvd_reg <= dvd_reg << 1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/bbt_sqrt.sv]
// Bit-serial floor square root, one root bit per cycle.
module bbt_sqrt #(
    parameter int RW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);
    localparam int CNW = $clog2(RW+1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [2*RW-1:0] x_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [RW+3:0]   shifted;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    always_comb
    begin
        shifted = {rem_reg, x_reg[2*RW-1:2*RW-2]};
        trial   = (RW+4)'({root_reg, 2'b01});
        diff    = shifted - trial;
        ge      = shifted >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
            x_reg    <= x_reg << 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/core/bbt_datapath.sv]
// Datapath: price ring, running sum, window walk, divider, square root, bands.
module bbt_datapath #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bbt_pkg::bbt_cmd_t                    cmd,
    output bbt_pkg::bbt_status_t                 st,
    input  logic [bbt_pkg::PRICE_W-1:0]          price,
    input  logic                                 cfg_write,
    input  logic [bbt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bbt_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic signed [bbt_pkg::BAND_W-1:0]    upper_band,
    output logic signed [bbt_pkg::BAND_W-1:0]    lower_band,
    output logic [bbt_pkg::BWID_W-1:0]           bandwidth
);
    import bbt_pkg::*;

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = PRICE_W + CW;
    localparam int ACW   = 2 * PRICE_W + CW;
    localparam int DW    = ACW;
    localparam int DCW   = $clog2(DW + 1);
    localparam int BWD_W = PRICE_W + BW_FRAC;
    localparam int LIM_W = PRICE_W + BW_LIM_SH;
    localparam int MP_W  = PRICE_W + GAIN_W;
    localparam int EW    = ((OFF_W > BAND_W) ? OFF_W : BAND_W) + 2;

    logic [PRICE_W-1:0] ring [WINDOW_MAX];
    logic [PRICE_W-1:0] rd_data_reg;
    logic [PRICE_W-1:0] price_reg;

    logic [SW-1:0]      sum_reg;
    logic [AW-1:0]      wp_reg;
    logic [CW-1:0]      fill_reg;
    logic [WL_W-1:0]    wl_reg;
    logic [GAIN_W-1:0]  gain_reg;

    logic [PRICE_W-1:0]   mean_reg;
    logic [2*PRICE_W-1:0] var_reg;
    logic [PRICE_W-1:0]   dev_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [BWID_W-1:0]    bw_reg;
    bbt_div_sel_t         div_sel_reg;

    logic                 walk_active_reg;
    logic [CW-1:0]        walk_cnt_reg;
    logic [AW-1:0]        walk_addr_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic [PRICE_W-1:0]   diff_reg;
    logic [2*PRICE_W-1:0] prod_reg;
    logic [ACW-1:0]       acc_reg;

    logic                 out_valid_reg;
    logic [BAND_W-1:0]    upper_reg;
    logic [BAND_W-1:0]    lower_reg;
    logic [BWID_W-1:0]    bwo_reg;

    logic [CW-1:0]        n;
    logic [CW:0]          back_sum;
    logic [AW-1:0]        back_addr;
    logic                 full;
    logic                 walk_issue;
    logic                 walk_done;
    logic [AW-1:0]        rd_addr;
    logic                 ring_re;
    logic [AW-1:0]        wp_inc;
    logic [AW-1:0]        walk_inc;

    logic [DW-1:0]        div_dividend;
    logic [DCW-1:0]       div_iters;
    logic [PRICE_W-1:0]   div_divisor;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic                 sqrt_done;
    logic [PRICE_W-1:0]   sqrt_root;

    logic [MP_W-1:0]      gain_prod;
    logic [EW-1:0]        up_w;
    logic [EW-1:0]        lo_w;
    logic [BAND_W-1:0]    up_sat;
    logic [BAND_W-1:0]    lo_sat;

    always_comb
    begin
        if (wl_reg == '0)
            n = CW'(1);
        else if (32'(wl_reg) > 32'(WINDOW_MAX))
            n = CW'(WINDOW_MAX);
        else
            n = CW'(wl_reg);
    end

    // oldest entry of the window, counted back from the write pointer
    always_comb
    begin
        back_sum = (CW+1)'(wp_reg) + (CW+1)'(WINDOW_MAX) - (CW+1)'(n);
        if (back_sum >= (CW+1)'(WINDOW_MAX))
            back_addr = AW'(back_sum - (CW+1)'(WINDOW_MAX));
        else
            back_addr = AW'(back_sum);
    end

    assign wp_inc   = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
    assign walk_inc = (walk_addr_reg == AW'(WINDOW_MAX - 1)) ? '0 : walk_addr_reg + 1'b1;
    assign full     = fill_reg >= n;

    assign walk_issue = walk_active_reg && (walk_cnt_reg != n);
    assign walk_done  = walk_active_reg && (walk_cnt_reg == n) && !v1_reg && !v2_reg && !v3_reg;
    assign rd_addr    = walk_active_reg ? walk_addr_reg : back_addr;
    assign ring_re    = cmd.rd_old | walk_issue;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            ring[wp_reg] <= price_reg;
        if (ring_re)
            rd_data_reg <= ring[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
            wl_reg   <= WL_RST;
            gain_reg <= GAIN_RST;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WINDOW:
                    begin
                        wl_reg   <= cfg_data[WL_W-1:0];
                        fill_reg <= '0;
                        sum_reg  <= '0;
                    end
                    CFG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.update)
            begin
                // drop the oldest price once the window is full
                sum_reg <= sum_reg - (full ? SW'(rd_data_reg) : SW'(0)) + SW'(price_reg);
                wp_reg  <= wp_inc;
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
            price_reg <= price;
    end

    // window walk: read, |v - mean|, square, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_active_reg <= 1'b0;
            walk_cnt_reg    <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
        end
        else
        begin
            v1_reg <= walk_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.walk_start)
            begin
                walk_active_reg <= 1'b1;
                walk_cnt_reg    <= '0;
            end
            else if (walk_done)
                walk_active_reg <= 1'b0;
            else if (walk_issue)
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
            walk_addr_reg <= back_addr;
        else if (walk_issue)
            walk_addr_reg <= walk_inc;
        if (v1_reg)
            diff_reg <= (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                                  : mean_reg - rd_data_reg;
        if (v2_reg)
            prod_reg <= (2*PRICE_W)'(diff_reg) * (2*PRICE_W)'(diff_reg);
        if (cmd.walk_start)
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_reg + ACW'(prod_reg);
    end

    // one divider shared by mean, variance and bandwidth; dividend left-aligned
    always_comb
    begin
        case (cmd.div_sel)
            DIV_MEAN:
            begin
                div_dividend = DW'(sum_reg) << (DW - SW);
                div_iters    = DCW'(SW);
                div_divisor  = PRICE_W'(n);
            end
            DIV_VAR:
            begin
                div_dividend = DW'(acc_reg);
                div_iters    = DCW'(ACW);
                div_divisor  = PRICE_W'(n);
            end
            DIV_BW:
            begin
                div_dividend = DW'({dev_reg, {BW_FRAC{1'b0}}}) << (DW - BWD_W);
                div_iters    = DCW'(BWD_W);
                div_divisor  = mean_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_iters    = DCW'(1);
                div_divisor  = PRICE_W'(1);
            end
        endcase
    end

    bbt_div #(
        .DW (DW),
        .VW (PRICE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .iters    (div_iters),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    bbt_sqrt #(
        .RW (PRICE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (var_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign gain_prod = MP_W'(gain_reg) * MP_W'(dev_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            div_sel_reg <= cmd.div_sel;
        if (div_done)
        begin
            case (div_sel_reg)
                DIV_MEAN: mean_reg <= div_quo[PRICE_W-1:0];
                DIV_VAR:  var_reg  <= div_quo[2*PRICE_W-1:0];
                DIV_BW:   bw_reg   <= div_quo[BWID_W-1:0];
                default: ;
            endcase
        end
        if (cmd.bw_sat)
            bw_reg <= '1;
        if (sqrt_done)
            dev_reg <= sqrt_root;
        if (cmd.mul)
            off_reg <= gain_prod[MP_W-1:GAIN_FRAC];
    end

    // bands in two's complement, clamped to the signed output range
    always_comb
    begin
        up_w = EW'(mean_reg) + EW'(off_reg);
        lo_w = EW'(mean_reg) - EW'(off_reg);
        if ((&up_w[EW-1:BAND_W-1]) || !(|up_w[EW-1:BAND_W-1]))
            up_sat = up_w[BAND_W-1:0];
        else if (up_w[EW-1])
            up_sat = {1'b1, {(BAND_W-1){1'b0}}};
        else
            up_sat = {1'b0, {(BAND_W-1){1'b1}}};
        if ((&lo_w[EW-1:BAND_W-1]) || !(|lo_w[EW-1:BAND_W-1]))
            lo_sat = lo_w[BAND_W-1:0];
        else if (lo_w[EW-1])
            lo_sat = {1'b1, {(BAND_W-1){1'b0}}};
        else
            lo_sat = {1'b0, {(BAND_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            upper_reg <= up_sat;
            lower_reg <= lo_sat;
            bwo_reg   <= bw_reg;
        end
    end

    always_comb
    begin
        st.will_emit = ((CW+1)'(fill_reg) + 1'b1) >= (CW+1)'(n);
        st.div_done  = div_done;
        st.walk_done = walk_done;
        st.sqrt_done = sqrt_done;
        st.bw_sat    = (mean_reg == '0) ||
                       (LIM_W'(dev_reg) >= (LIM_W'(mean_reg) << BW_LIM_SH));
        st.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign upper_band = $signed(upper_reg);
    assign lower_band = $signed(lower_reg);
    assign bandwidth  = bwo_reg;

endmodule

[rtl/core/bbt_ctrl.sv]
// Controller state machine sequencing one price word through the datapath.
module bbt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bbt_pkg::bbt_status_t st,
    output bbt_pkg::bbt_cmd_t    cmd
);
    import bbt_pkg::*;

    bbt_state_t state_reg;
    bbt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_RD_OLD;
                end
            end
            ST_RD_OLD:
            begin
                cmd.rd_old = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = st.will_emit ? ST_MEAN_S : ST_IDLE;
            end
            ST_MEAN_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = ST_MEAN_W;
            end
            ST_MEAN_W:
            begin
                if (st.div_done)
                    state_next = ST_WALK_S;
            end
            ST_WALK_S:
            begin
                cmd.walk_start = 1'b1;
                state_next     = ST_WALK_W;
            end
            ST_WALK_W:
            begin
                if (st.walk_done)
                    state_next = ST_VAR_S;
            end
            ST_VAR_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VAR;
                state_next    = ST_VAR_W;
            end
            ST_VAR_W:
            begin
                if (st.div_done)
                    state_next = ST_SQRT_S;
            end
            ST_SQRT_S:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_W;
            end
            ST_SQRT_W:
            begin
                if (st.sqrt_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_BW_S;
            end
            ST_BW_S:
            begin
                // zero mean or ratio out of range: pin bandwidth to full scale
                if (st.bw_sat)
                begin
                    cmd.bw_sat = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_BW;
                    state_next    = ST_BW_W;
                end
            end
            ST_BW_W:
            begin
                if (st.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for bollinger_band_tracker_core with a band predictor.
module tb_top;
    import bbt_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [63:0] BAND_POS_MAX = 64'h7FFF_FFFF_FFFF;
    localparam logic [63:0] BAND_NEG_MAX = 64'h8000_0000_0000;

    typedef struct {
        logic [BAND_W-1:0] upper;
        logic [BAND_W-1:0] lower;
        logic [BWID_W-1:0] bw;
    } band_word_t;

    class band_scoreboard;
        logic [PRICE_W-1:0] ring [RING_DEPTH];
        logic [63:0]        sum;
        int unsigned        wr_ptr;
        int unsigned        fill;
        int unsigned        win_len;
        int unsigned        gain;
        band_word_t         expected_words[$];
        int unsigned        mismatches;
        int unsigned        prices_seen;
        int unsigned        words_seen;

        function new();
            sum = 0;
            wr_ptr = 0;
            fill = 0;
            win_len = WL_RST;
            gain = GAIN_RST;
            mismatches = 0;
            prices_seen = 0;
            words_seen = 0;
        endfunction

        function void set_window(logic [CFG_DATA_W-1:0] v);
            win_len = v[WL_W-1:0];
            fill = 0;
            sum = 0;
        endfunction

        function void set_gain(logic [CFG_DATA_W-1:0] v);
            gain = v;
        endfunction

        function void note_price(logic [PRICE_W-1:0] p);
            int unsigned n;
            logic [63:0]  mean;
            logic [63:0]  d;
            logic [63:0]  v;
            logic [127:0] acc;
            logic [127:0] var_q;
            logic [127:0] sq;
            logic [63:0]  dev;
            logic [63:0]  cand;
            logic [63:0]  off;
            logic [63:0]  upper;
            logic [63:0]  lower;
            logic [63:0]  neg;
            logic [127:0] bwq;
            band_word_t   w;
            n = (win_len == 0) ? 1 : (win_len > RING_DEPTH) ? RING_DEPTH : win_len;
            prices_seen++;
            if (fill >= n)
                sum -= ring[(wr_ptr + RING_DEPTH - n) % RING_DEPTH];
            ring[wr_ptr] = p;
            sum += p;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (fill < n)
                fill++;
            if (fill < n)
                return;
            mean = sum / n;
            acc = 0;
            for (int k = 0; k < n; k++)
            begin
                v = ring[(wr_ptr + RING_DEPTH - n + k) % RING_DEPTH];
                d = (v >= mean) ? v - mean : mean - v;
                acc += {64'd0, d} * {64'd0, d};
            end
            var_q = acc / n;
            dev = 0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = dev | (64'd1 << b);
                sq = {64'd0, cand} * {64'd0, cand};
                if (sq <= var_q)
                    dev = cand;
            end
            off = (gain * dev) >> GAIN_FRAC;
            upper = mean + off;
            if (upper > BAND_POS_MAX)
                upper = BAND_POS_MAX;
            if (mean >= off)
            begin
                lower = mean - off;
                if (lower > BAND_POS_MAX)
                    lower = BAND_POS_MAX;
            end
            else
            begin
                neg = off - mean;
                if (neg > BAND_NEG_MAX)
                    neg = BAND_NEG_MAX;
                lower = 64'd0 - neg;
            end
            if (mean == 0 || dev >= (mean << BW_LIM_SH))
                w.bw = '1;
            else
            begin
                bwq = ({64'd0, dev} << BW_FRAC) / mean;
                w.bw = (bwq > 128'hFFFF_FFFF) ? '1 : bwq[BWID_W-1:0];
            end
            w.upper = upper[BAND_W-1:0];
            w.lower = lower[BAND_W-1:0];
            expected_words.insert(expected_words.size(), w);
        endfunction

        function void fail_note(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void check_word(logic [BAND_W-1:0] u, logic [BAND_W-1:0] l,
                                 logic [BWID_W-1:0] b);
            band_word_t w;
            words_seen++;
            if (expected_words.size() == 0)
            begin
                fail_note($sformatf("unexpected word upper=%h lower=%h bw=%h", u, l, b));
                return;
            end
            w = expected_words.pop_front();
            if (u !== w.upper)
                fail_note($sformatf("upper_band exp %h got %h", w.upper, u));
            if (l !== w.lower)
                fail_note($sformatf("lower_band exp %h got %h", w.lower, l));
            if (b !== w.bw)
                fail_note($sformatf("bandwidth exp %h got %h", w.bw, b));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PRICE_W-1:0]    price;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [BAND_W-1:0] upper_band;
    logic signed [BAND_W-1:0] lower_band;
    logic [BWID_W-1:0]     bandwidth;

    band_scoreboard sb;
    int unsigned    cycles;
    int unsigned    burst_left;
    int unsigned    phases;
    bit             gaps_on;
    bit             hold_req;

    bollinger_band_tracker_core dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .price(price), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_valid(out_valid), .out_stall(out_stall),
        .upper_band(upper_band), .lower_band(lower_band), .bandwidth(bandwidth)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d words outstanding", sb.expected_words.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(upper_band, lower_band, bandwidth);
    end

    // Receiver stall pattern; long hold-off on request.
    initial
    begin
        int unsigned pct;
        out_stall = 0;
        pct = 0;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1;
                repeat (3000) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 60;
                    default: pct = 90;
                endcase
                repeat ($urandom_range(50, 400))
                begin
                    out_stall <= ($urandom_range(0, 99) < pct);
                    @(posedge clk);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    task automatic idle_gap(int unsigned n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_price(logic [PRICE_W-1:0] p);
        if (gaps_on && burst_left == 0)
        begin
            idle_gap($urandom_range(1, 30));
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1;
        price <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_price(p);
    endtask

    // Hold the sender until every expected word has come, then let the core settle.
    task automatic drain();
        in_valid <= 0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 0;
        @(posedge clk);
        if (idx == CFG_WINDOW)
            sb.set_window(v);
        else
            sb.set_gain(v);
    endtask

    function automatic logic [PRICE_W-1:0] pick_price(logic [PRICE_W-1:0] base);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return '0;
            2: return '1;
            3: return base;
            default: return base + $urandom_range(0, 32'h0003_FFFF) - 32'h0001_FFFF;
        endcase
    endfunction

    initial
    begin
        logic [PRICE_W-1:0] base;
        int unsigned sent;
        int unsigned cnt;
        sb = new();
        cycles = 0;
        burst_left = 0;
        gaps_on = 0;
        hold_req = 0;
        phases = 0;
        rst_n = 0;
        in_valid = 0;
        price = 0;
        cfg_write = 0;
        cfg_index = CFG_WINDOW;
        cfg_data = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: window of two at default gain first, with zero mean and full-scale
        // prices, then window of one, zero gain, window zero and maximum gain.
        write_reg(CFG_WINDOW, 2);
        send_price(0);
        send_price(0);
        send_price('1);
        send_price('1);
        send_price(0);
        send_price(32'h0001_0000);
        drain();
        write_reg(CFG_WINDOW, 1);
        write_reg(CFG_GAIN, 0);
        send_price(32'h1234_5678);
        send_price('1);
        send_price(0);
        drain();
        write_reg(CFG_WINDOW, 0);
        write_reg(CFG_GAIN, 16'hFFFF);
        send_price(32'hAAAA_5555);
        send_price(32'h5555_AAAA);
        drain();
        write_reg(CFG_WINDOW, 3);
        write_reg(CFG_GAIN, 1);
        send_price(0);
        send_price('1);
        send_price(0);
        send_price('1);
        send_price(32'h0000_0001);
        drain();
        sent = sb.prices_seen;

        // Random phases; the second one holds the receiver off for a long stretch.
        while (sb.prices_seen < sent + 650)
        begin
            phases++;
            case ($urandom_range(0, 7))
                0: write_reg(CFG_WINDOW, 64);
                1: write_reg(CFG_WINDOW, CFG_DATA_W'($urandom_range(65, 127)));
                2: write_reg(CFG_WINDOW, 0);
                3: write_reg(CFG_WINDOW, 1);
                default: write_reg(CFG_WINDOW, CFG_DATA_W'($urandom_range(2, 10)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_GAIN, 0);
                1: write_reg(CFG_GAIN, 16'hFFFF);
                2: write_reg(CFG_GAIN, 1);
                default: write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            endcase
            gaps_on = (phases % 3) != 0;
            if (phases == 2)
                hold_req = 1;
            base = $urandom();
            cnt = $urandom_range(20, 90);
            for (int i = 0; i < cnt; i++)
            begin
                send_price(pick_price(base));
                if (phases == 4 && i == cnt / 2)
                    drain();
            end
            drain();
        end

        in_valid <= 0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d prices and %0d band words over %0d random phases",
                 sb.prices_seen, sb.words_seen, phases);
        $display("mismatches %0d, words left over %0d", sb.mismatches,
                 sb.expected_words.size());
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
